[rtl/csac_pkg.sv]
package csac_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COST_WIDTH_DEF  = 48;

  localparam int CORDIC_STEPS = 24;
  localparam int LOG_STEPS    = 24;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);

  // angles are signed Q.24 radians; range stays inside +/- 2^28
  localparam int ANG_W = 29;
  localparam logic signed [ANG_W-1:0] ANG_PI = 29'sd52707179;
  localparam logic [23:0] LN2_Q24 = 24'd11629080;

  // log mantissa register, Q2.30 plus headroom
  localparam int LOG_ZW = 32;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_VINIT, S_VSTEP, S_VSTORE, S_MCHK, S_NINIT, S_NORM,
    S_LINIT, S_LOG, S_LSTORE, S_LN, S_SQ, S_ACC, S_FINISH
  } state_t;

  typedef struct packed {
    logic             load;
    logic             degen;
    logic             vinit;
    logic             vstep;
    logic             vstore;
    logic             ninit;
    logic             nstep;
    logic             linit;
    logic             lstep;
    logic             lstore;
    logic             ln;
    logic             sq;
    logic             acc;
    logic             emit;
    logic             sel;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic delta_zero;
    logic mag_zero;
    logic norm_done;
    logic last;
    logic out_busy;
  } sts_t;

  function automatic logic signed [ANG_W-1:0] atan_q24(input logic [CNT_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 29'sd13176795;
      5'd1:    v = 29'sd7778716;
      5'd2:    v = 29'sd4110060;
      5'd3:    v = 29'sd2086331;
      5'd4:    v = 29'sd1047214;
      5'd5:    v = 29'sd524117;
      5'd6:    v = 29'sd262123;
      5'd7:    v = 29'sd131069;
      5'd8:    v = 29'sd65536;
      5'd9:    v = 29'sd32768;
      5'd10:   v = 29'sd16384;
      5'd11:   v = 29'sd8192;
      5'd12:   v = 29'sd4096;
      5'd13:   v = 29'sd2048;
      5'd14:   v = 29'sd1024;
      5'd15:   v = 29'sd512;
      5'd16:   v = 29'sd256;
      5'd17:   v = 29'sd128;
      5'd18:   v = 29'sd64;
      5'd19:   v = 29'sd32;
      5'd20:   v = 29'sd16;
      5'd21:   v = 29'sd8;
      5'd22:   v = 29'sd4;
      5'd23:   v = 29'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/csac_if.sv]
interface csac_in_if #(
  parameter int COORD_WIDTH = csac_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_curve_x;
  logic signed [COORD_WIDTH-1:0] first_curve_y;
  logic signed [COORD_WIDTH-1:0] second_curve_x;
  logic signed [COORD_WIDTH-1:0] second_curve_y;
  logic                          final_sample;

  modport source (output valid, first_curve_x, first_curve_y, second_curve_x,
                  second_curve_y, final_sample, input ready);
  modport sink   (input valid, first_curve_x, first_curve_y, second_curve_x,
                  second_curve_y, final_sample, output ready);
endinterface

interface csac_out_if #(
  parameter int COST_WIDTH = csac_pkg::COST_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COST_WIDTH-1:0] total_cost;
  logic                  degenerate_segment;
  logic                  cost_saturated;

  modport source (output valid, total_cost, degenerate_segment, cost_saturated,
                  input ready);
  modport sink   (input valid, total_cost, degenerate_segment, cost_saturated,
                  output ready);
endinterface

[rtl/curve_scale_angle_cost_top.sv]
// Curve scale-and-angle cost. One transfer on in_ch carries a matching sample
// pair of two curves (Q16.16); the block keeps the previous pair and, for each
// segment, adds ln(L2/L1)^2 + (angle2 - angle1)^2 to a saturating Q24.24 cost.
// The angle difference is used raw, never wrapped. A transfer with
// final_sample set produces one result transfer on out_ch (cost, a flag for
// any zero-length segment, a flag for saturation) and starts a new run.
// Items are handled one at a time. The first item of a run only stores the
// pair. A segment is steered through the single shared 24-step CORDIC
// vectoring unit, used once per curve, then a normalize by one-bit shifts
// and the 24-step squaring log2 unit, also used once per curve. A
// zero-length segment skips the log2 unit and is not accumulated. A result
// waits in an output register while the next run's items are taken in.
module curve_scale_angle_cost_top #(
  parameter int COORD_WIDTH = csac_pkg::COORD_WIDTH_DEF,
  parameter int COST_WIDTH  = csac_pkg::COST_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  csac_in_if.sink       in_ch,
  csac_out_if.source    out_ch
);

  csac_pkg::cmd_t cmd;
  csac_pkg::sts_t sts;

  // sequencer: walks each segment through CORDIC, log2 and accumulate
  csac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: held pair, shared CORDIC, log2 unit, cost and output register
  csac_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .COST_WIDTH  (COST_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_fx     (in_ch.first_curve_x),
    .in_fy     (in_ch.first_curve_y),
    .in_sx     (in_ch.second_curve_x),
    .in_sy     (in_ch.second_curve_y),
    .in_last   (in_ch.final_sample),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_cost  (out_ch.total_cost),
    .out_degen (out_ch.degenerate_segment),
    .out_sat   (out_ch.cost_saturated)
  );

`ifndef ASSERT_OFF
  // hold off new input once an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in work");

  // a saturated run reports the full-scale cost
  a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.cost_saturated) |-> (&out_ch.total_cost))
    else $error("saturated cost is not full scale");

  // drop any pending result on reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

[rtl/csac_ctrl.sv]
module csac_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  csac_pkg::sts_t  sts,
  output csac_pkg::cmd_t  cmd
);

  localparam logic [csac_pkg::CNT_W-1:0] CORDIC_LAST =
    csac_pkg::CNT_W'(csac_pkg::CORDIC_STEPS - 1);
  localparam logic [csac_pkg::CNT_W-1:0] LOG_LAST =
    csac_pkg::CNT_W'(csac_pkg::LOG_STEPS - 1);

  csac_pkg::state_t           state_r, state_nxt;
  logic                       sel_r, sel_nxt;
  logic [csac_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csac_pkg::S_IDLE;
      sel_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    cmd.cnt   = cnt_r;
    in_ready  = 1'b0;
    unique case (state_r)
      csac_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.have_prev ? csac_pkg::S_CHK : csac_pkg::S_FINISH;
        end
      end
      csac_pkg::S_CHK: begin
        sel_nxt = 1'b0;
        if (sts.delta_zero) begin
          cmd.degen = 1'b1;
          state_nxt = csac_pkg::S_FINISH;
        end else begin
          state_nxt = csac_pkg::S_VINIT;
        end
      end
      csac_pkg::S_VINIT: begin
        cmd.vinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = csac_pkg::S_VSTEP;
      end
      csac_pkg::S_VSTEP: begin
        cmd.vstep = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CORDIC_LAST) state_nxt = csac_pkg::S_VSTORE;
      end
      csac_pkg::S_VSTORE: begin
        cmd.vstore = 1'b1;
        sel_nxt    = ~sel_r;
        state_nxt  = sel_r ? csac_pkg::S_MCHK : csac_pkg::S_VINIT;
      end
      csac_pkg::S_MCHK: begin
        sel_nxt = 1'b0;
        if (sts.mag_zero) begin
          cmd.degen = 1'b1;
          state_nxt = csac_pkg::S_FINISH;
        end else begin
          state_nxt = csac_pkg::S_NINIT;
        end
      end
      csac_pkg::S_NINIT: begin
        cmd.ninit = 1'b1;
        state_nxt = csac_pkg::S_NORM;
      end
      csac_pkg::S_NORM: begin
        if (sts.norm_done) state_nxt = csac_pkg::S_LINIT;
        else cmd.nstep = 1'b1;
      end
      csac_pkg::S_LINIT: begin
        cmd.linit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = csac_pkg::S_LOG;
      end
      csac_pkg::S_LOG: begin
        cmd.lstep = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LOG_LAST) state_nxt = csac_pkg::S_LSTORE;
      end
      csac_pkg::S_LSTORE: begin
        cmd.lstore = 1'b1;
        sel_nxt    = ~sel_r;
        state_nxt  = sel_r ? csac_pkg::S_LN : csac_pkg::S_NINIT;
      end
      csac_pkg::S_LN: begin
        cmd.ln    = 1'b1;
        state_nxt = csac_pkg::S_SQ;
      end
      csac_pkg::S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = csac_pkg::S_ACC;
      end
      csac_pkg::S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = csac_pkg::S_FINISH;
      end
      csac_pkg::S_FINISH: begin
        if (!sts.last) begin
          state_nxt = csac_pkg::S_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = csac_pkg::S_IDLE;
        end
      end
      default: state_nxt = csac_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/csac_dp.sv]
module csac_dp #(
  parameter int COORD_WIDTH = csac_pkg::COORD_WIDTH_DEF,
  parameter int COST_WIDTH  = csac_pkg::COST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csac_pkg::cmd_t                cmd,
  output csac_pkg::sts_t                sts,
  input  logic signed [COORD_WIDTH-1:0] in_fx,
  input  logic signed [COORD_WIDTH-1:0] in_fy,
  input  logic signed [COORD_WIDTH-1:0] in_sx,
  input  logic signed [COORD_WIDTH-1:0] in_sy,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [COST_WIDTH-1:0]         out_cost,
  output logic                          out_degen,
  output logic                          out_sat
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int MW   = (COORD_WIDTH + 4 > 31) ? COORD_WIDTH + 4 : 31;
  localparam int PW   = $clog2(MW);
  localparam int LW   = PW + 25;
  localparam int AW   = csac_pkg::ANG_W;
  localparam int ZW   = csac_pkg::LOG_ZW;
  localparam int SMW  = LW + 24;
  localparam int SW   = LW + 1;
  localparam int TSW  = ((2 * SW > 2 * AW) ? 2 * SW : 2 * AW) + 1;
  localparam int TW   = TSW - 24;
  localparam int CW2  = ((TW > COST_WIDTH) ? TW : COST_WIDTH) + 1;
  localparam logic [CW2-1:0] COST_MAX = {{(CW2 - COST_WIDTH){1'b0}}, {COST_WIDTH{1'b1}}};

  logic signed [COORD_WIDTH-1:0] pfx_r, pfy_r, psx_r, psy_r;
  logic                          have_prev_r, last_r;
  logic [COST_WIDTH-1:0]         acc_r;
  logic                          degen_r, sat_r;
  logic signed [DW-1:0]          dfx_r, dfy_r, dsx_r, dsy_r;
  logic signed [MW-1:0]          cx_r, cy_r;
  logic signed [AW-1:0]          cz_r;
  logic signed [AW-1:0]          ang_r [2];
  logic [MW-1:0]                 mag_r [2];
  logic [MW-1:0]                 nrm_r;
  logic [PW-1:0]                 p_r;
  logic [ZW-1:0]                 lz_r;
  logic [23:0]                   frac_r;
  logic signed [LW-1:0]          log_r [2];
  logic [SMW-1:0]                sm_r;
  logic [AW-1:0]                 am_r;
  logic [2*SW-1:0]               ss_r;
  logic [2*AW-1:0]               aa_r;
  logic                          out_valid_r;
  logic [COST_WIDTH-1:0]         out_cost_r;
  logic                          out_degen_r, out_sat_r;

  function automatic logic signed [DW-1:0] delta(input logic signed [COORD_WIDTH-1:0] a,
                                                 input logic signed [COORD_WIDTH-1:0] b);
    return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  endfunction

  logic signed [DW-1:0]     vdx, vdy;
  logic signed [MW-1:0]     vx, vy, xs, ys;
  logic signed [AW-1:0]     at;
  logic [2*ZW-1:0]          zz;
  logic [ZW+1:0]            zs;
  logic signed [LW-1:0]     dlog;
  logic [LW-1:0]            dabs;
  logic [SMW:0]             srnd;
  logic [SW-1:0]            sv;
  logic signed [AW:0]       adiff;
  logic [AW:0]              aabs;
  logic [TSW-1:0]           tsum;
  logic [CW2-1:0]           csum;

  always_comb begin
    vdx   = cmd.sel ? dsx_r : dfx_r;
    vdy   = cmd.sel ? dsy_r : dfy_r;
    vx    = {{(MW - DW){vdx[DW-1]}}, vdx};
    vy    = {{(MW - DW){vdy[DW-1]}}, vdy};
    xs    = cx_r >>> cmd.cnt;
    ys    = cy_r >>> cmd.cnt;
    at    = csac_pkg::atan_q24(cmd.cnt);
    zz    = lz_r * lz_r;
    zs    = zz[ZW+31:30];
    dlog  = log_r[1] - log_r[0];
    dabs  = dlog[LW-1] ? LW'(-dlog) : LW'(dlog);
    srnd  = {1'b0, sm_r} + (SMW + 1)'(24'h800000);
    sv    = srnd[SMW:24];
    adiff = {ang_r[1][AW-1], ang_r[1]} - {ang_r[0][AW-1], ang_r[0]};
    aabs  = adiff[AW] ? (AW + 1)'(-adiff) : (AW + 1)'(adiff);
    tsum  = TSW'(ss_r) + TSW'(aa_r) + TSW'(24'h800000);
    csum  = CW2'(acc_r) + CW2'(tsum[TSW-1:24]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_r       <= '0;
      pfy_r       <= '0;
      psx_r       <= '0;
      psy_r       <= '0;
      have_prev_r <= 1'b0;
      last_r      <= 1'b0;
      acc_r       <= '0;
      degen_r     <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        dfx_r       <= delta(in_fx, pfx_r);
        dfy_r       <= delta(in_fy, pfy_r);
        dsx_r       <= delta(in_sx, psx_r);
        dsy_r       <= delta(in_sy, psy_r);
        pfx_r       <= in_fx;
        pfy_r       <= in_fy;
        psx_r       <= in_sx;
        psy_r       <= in_sy;
        have_prev_r <= 1'b1;
        last_r      <= in_last;
      end
      if (cmd.degen) degen_r <= 1'b1;
      if (cmd.acc) begin
        if (csum >= COST_MAX) begin
          acc_r <= {COST_WIDTH{1'b1}};
          sat_r <= 1'b1;
        end else begin
          acc_r <= csum[COST_WIDTH-1:0];
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        acc_r       <= '0;
        degen_r     <= 1'b0;
        sat_r       <= 1'b0;
        have_prev_r <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.vinit) begin
      if (vx < 0) begin
        cz_r <= (vy >= 0) ? csac_pkg::ANG_PI : -csac_pkg::ANG_PI;
        cx_r <= -vx;
        cy_r <= -vy;
      end else begin
        cz_r <= '0;
        cx_r <= vx;
        cy_r <= vy;
      end
    end
    if (cmd.vstep) begin
      if (cy_r >= 0) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end
    end
    if (cmd.vstore) begin
      ang_r[cmd.sel] <= cz_r;
      mag_r[cmd.sel] <= (cx_r > 0) ? cx_r : '0;
    end
    if (cmd.ninit) begin
      nrm_r <= mag_r[cmd.sel];
      p_r   <= PW'(MW - 1);
    end
    if (cmd.nstep) begin
      nrm_r <= {nrm_r[MW-2:0], 1'b0};
      p_r   <= p_r - 1'b1;
    end
    if (cmd.linit) begin
      lz_r   <= {1'b0, nrm_r[MW-1 -: 31]};
      frac_r <= '0;
    end
    if (cmd.lstep) begin
      if (zs[ZW+1:31] != '0) begin
        frac_r <= {frac_r[22:0], 1'b1};
        lz_r   <= zs[ZW:1];
      end else begin
        frac_r <= {frac_r[22:0], 1'b0};
        lz_r   <= zs[ZW-1:0];
      end
    end
    if (cmd.lstore) log_r[cmd.sel] <= {1'b0, p_r, frac_r};
    if (cmd.ln) begin
      sm_r <= dabs * csac_pkg::LN2_Q24;
      am_r <= aabs[AW-1:0];
    end
    if (cmd.sq) begin
      ss_r <= sv * sv;
      aa_r <= am_r * am_r;
    end
    if (cmd.emit) begin
      out_cost_r  <= acc_r;
      out_degen_r <= degen_r;
      out_sat_r   <= sat_r;
    end
  end

  assign sts.have_prev  = have_prev_r;
  assign sts.delta_zero = (dfx_r == '0 && dfy_r == '0) || (dsx_r == '0 && dsy_r == '0);
  assign sts.mag_zero   = (mag_r[0] == '0) || (mag_r[1] == '0);
  assign sts.norm_done  = nrm_r[MW-1];
  assign sts.last       = last_r;
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_cost  = out_cost_r;
  assign out_degen = out_degen_r;
  assign out_sat   = out_sat_r;

endmodule
